FILE: hdl/evad_pkg.sv
// Package for the energy voice activity detector.
// Holds the controller/datapath command and status types and the fixed constants.
// No dependencies.
package evad_pkg;

	localparam int RATE_W   = 18;
	localparam int THR_W    = 31;
	localparam int MS_W     = 32;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int SAMPLE_W = 16;
	localparam int MS_PER_S_W = 10;

	localparam logic [MS_PER_S_W-1:0] MS_PER_S = 10'd1000;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SILENCE_END_MS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_UTTERANCE_MS = 2'd3;

	localparam logic [RATE_W-1:0] RST_SAMPLE_RATE      = 18'd16000;
	localparam logic [THR_W-1:0]  RST_ENERGY_THRESHOLD = 31'd100000;
	localparam logic [MS_W-1:0]   RST_SILENCE_END_MS   = 32'd800;
	localparam logic [MS_W-1:0]   RST_MAX_UTTERANCE_MS = 32'd10000;

	typedef struct packed {
		logic acc;      // accumulate an audio sample
		logic restart;  // clear utterance timers
		logic load;     // start chunk-end evaluation
		logic step;     // one divider iteration
		logic commit;   // update timers, load result register
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

FILE: hdl/evad_in_if.sv
// Input channel of the voice activity detector: valid/ready plus one audio item.
// Depends on evad_pkg.
interface evad_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 kind;
	logic signed [evad_pkg::SAMPLE_W-1:0] sample;
	logic                                 last;

	modport source (output valid, kind, sample, last, input ready);
	modport sink (input valid, kind, sample, last, output ready);
endinterface

FILE: hdl/evad_out_if.sv
// Result channel of the voice activity detector: valid/ready plus one chunk result.
// Depends on evad_pkg.
interface evad_out_if;
	logic                          valid;
	logic                          ready;
	logic                          voiced;
	logic                          utt_done;
	logic [evad_pkg::MS_W-1:0]     elapsed_ms;

	modport source (output valid, voiced, utt_done, elapsed_ms, input ready);
	modport sink (input valid, voiced, utt_done, elapsed_ms, output ready);
endinterface

FILE: hdl/evad_ctrl.sv
// Controller of the voice activity detector: sequences sample intake and the
// chunk-end evaluation. Depends on evad_pkg.
module evad_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_kind,
	input  logic             in_last,
	output logic             in_ready,
	input  evad_pkg::sts_t   sts,
	output evad_pkg::cmd_t   cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd         = '0;
		cmd.acc     = accept && !in_kind;
		cmd.restart = accept && in_kind;
		cmd.load    = (state_q == ST_LOAD);
		cmd.step    = (state_q == ST_DIV);
		cmd.commit  = (state_q == ST_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && !in_kind && in_last) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_last) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/evad_datapath.sv
// Datapath of the voice activity detector: config registers, square accumulator,
// threshold product, restoring divider for chunk milliseconds, timers, result register.
// Depends on evad_pkg.
module evad_datapath #(
	parameter int MAX_CHUNK = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  evad_pkg::cmd_t                        cmd,
	output evad_pkg::sts_t                        sts,
	input  logic                                  cfg_we,
	input  logic [evad_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [evad_pkg::CFG_W-1:0]            cfg_wdata,
	input  logic signed [evad_pkg::SAMPLE_W-1:0]  in_sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  out_voiced,
	output logic                                  out_utt_done,
	output logic [evad_pkg::MS_W-1:0]             out_elapsed_ms
);

	localparam int CNT_W  = $clog2(MAX_CHUNK + 1);
	localparam int SQ_W   = 2 * evad_pkg::SAMPLE_W;
	localparam int SUM_W  = SQ_W - 2 + CNT_W;
	localparam int PROD_W = evad_pkg::MS_W + CNT_W;
	localparam int NUM_W  = CNT_W + evad_pkg::MS_PER_S_W;
	localparam int DCNT_W = $clog2(NUM_W + 1);
	localparam int RATE_W = evad_pkg::RATE_W;
	localparam int MS_W   = evad_pkg::MS_W;

	// configuration
	logic [RATE_W-1:0]            rate_q;
	logic [evad_pkg::THR_W-1:0]   thr_q;
	logic [MS_W-1:0]              sil_end_q;
	logic [MS_W-1:0]              max_ms_q;

	// chunk and utterance state
	logic [SUM_W-1:0]             sum_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [MS_W-1:0]              silence_q;
	logic [MS_W-1:0]              total_q;
	logic                         seen_q;

	// evaluation
	logic [PROD_W-1:0]            prod_q;
	logic                         speech_q;
	logic [NUM_W-1:0]             num_q;
	logic [RATE_W-1:0]            rem_q;
	logic [DCNT_W-1:0]            div_cnt_q;

	// result register
	logic                         out_valid_q;
	logic                         out_speech_q;
	logic                         out_ended_q;
	logic [MS_W-1:0]              out_ms_q;

	logic [evad_pkg::SAMPLE_W-1:0] mag;
	logic [SQ_W-1:0]              square;
	logic [NUM_W-1:0]             num_init;
	logic [MS_W-1:0]              thr_p1;
	logic [PROD_W-1:0]            prod;
	logic [RATE_W-1:0]            divisor;
	logic [RATE_W:0]              rem_shift;
	logic                         q_bit;
	logic [MS_W:0]                total_sum;
	logic [MS_W:0]                silence_sum;
	logic [MS_W-1:0]              total_new;
	logic [MS_W-1:0]              silence_new;
	logic                         seen_new;
	logic                         ended;

	// |sample| fits 16 bits unsigned, including the most negative value
	assign mag    = in_sample[evad_pkg::SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
	assign square = mag * mag;

	assign num_init = NUM_W'(cnt_q) * NUM_W'(evad_pkg::MS_PER_S);
	// floor(sum / cnt) > thr  <=>  sum >= (thr + 1) * cnt
	assign thr_p1   = {1'b0, thr_q} + MS_W'(1);
	assign prod     = PROD_W'(thr_p1) * PROD_W'(cnt_q);

	assign divisor   = (rate_q == '0) ? RATE_W'(1) : rate_q;
	assign rem_shift = {rem_q, num_q[NUM_W-1]};
	assign q_bit     = (rem_shift >= {1'b0, divisor});

	// chunk milliseconds stay far below 2^32, so only the timer adds saturate
	assign total_sum   = {1'b0, total_q} + (MS_W + 1)'(num_q);
	assign silence_sum = {1'b0, silence_q} + (MS_W + 1)'(num_q);
	assign total_new   = total_sum[MS_W] ? '1 : total_sum[MS_W-1:0];
	assign silence_new = speech_q ? '0 :
		(silence_sum[MS_W] ? '1 : silence_sum[MS_W-1:0]);
	assign seen_new    = seen_q || speech_q;
	assign ended       = (seen_new && (silence_new >= sil_end_q)) || (total_new >= max_ms_q);

	assign sts.div_last = (div_cnt_q == DCNT_W'(1));
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign out_voiced     = out_speech_q;
	assign out_utt_done   = out_ended_q;
	assign out_elapsed_ms = out_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= evad_pkg::RST_SAMPLE_RATE;
			thr_q     <= evad_pkg::RST_ENERGY_THRESHOLD;
			sil_end_q <= evad_pkg::RST_SILENCE_END_MS;
			max_ms_q  <= evad_pkg::RST_MAX_UTTERANCE_MS;
		end else if (cfg_we) begin
			case (cfg_idx)
				evad_pkg::REG_SAMPLE_RATE:      rate_q    <= cfg_wdata[RATE_W-1:0];
				evad_pkg::REG_ENERGY_THRESHOLD: thr_q     <= cfg_wdata[evad_pkg::THR_W-1:0];
				evad_pkg::REG_SILENCE_END_MS:   sil_end_q <= cfg_wdata[MS_W-1:0];
				evad_pkg::REG_MAX_UTTERANCE_MS: max_ms_q  <= cfg_wdata[MS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			cnt_q     <= '0;
			silence_q <= '0;
			total_q   <= '0;
			seen_q    <= 1'b0;
		end else begin
			if (cmd.acc && (cnt_q < CNT_W'(MAX_CHUNK))) begin
				sum_q <= sum_q + SUM_W'(square);
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.restart) begin
				silence_q <= '0;
				total_q   <= '0;
				seen_q    <= 1'b0;
			end
			if (cmd.commit) begin
				sum_q     <= '0;
				cnt_q     <= '0;
				silence_q <= silence_new;
				total_q   <= total_new;
				seen_q    <= seen_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.load) begin
			div_cnt_q <= DCNT_W'(NUM_W);
		end else if (cmd.step) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	// restoring divider, one quotient bit per cycle shifted into num_q
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q  <= num_init;
			rem_q  <= '0;
			prod_q <= prod;
		end else if (cmd.step) begin
			num_q    <= {num_q[NUM_W-2:0], q_bit};
			rem_q    <= q_bit ? RATE_W'(rem_shift - {1'b0, divisor}) : rem_shift[RATE_W-1:0];
			speech_q <= (PROD_W'(sum_q) >= prod_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_speech_q <= speech_q;
			out_ended_q  <= ended;
			out_ms_q     <= total_new;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_CHUNK))
		else $error("sample count above chunk limit");

	a_commit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q && (cnt_q == '0) && (sum_q == '0))
		else $error("commit did not load result and clear accumulator");

	a_load_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (div_cnt_q == DCNT_W'(NUM_W)))
		else $error("divider not armed for a full quotient");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transaction completed");
`endif

endmodule

FILE: hdl/energy_voice_activity_detector.sv
// Top level of the energy-threshold voice activity detector.
// Depends on evad_pkg, evad_in_if, evad_out_if, evad_ctrl, evad_datapath.
//
//   channel  dir   handshake      payload
//   audio    in    valid/ready    kind, sample, last
//   result   out   valid/ready    voiced, utt_done, elapsed_ms
//   cfg      in    cfg_we only    cfg_idx, cfg_wdata
//
// A sample without last is accepted while the controller is idle. A chunk-closing
// sample holds intake through the load, divide and done states; the restoring divider
// yields one bit of the chunk millisecond count per cycle. There is no clearing pass.
// Control, accumulator and timer state reset to zero, config registers to defaults.
// A pending result does not block intake; a stalled result holds the next chunk end.
module energy_voice_activity_detector #(
	parameter int MAX_CHUNK = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	evad_in_if.sink                               audio,
	evad_out_if.source                            result,
	input  logic                                  cfg_we,
	input  logic [evad_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [evad_pkg::CFG_W-1:0]            cfg_wdata
);

	evad_pkg::cmd_t cmd;
	evad_pkg::sts_t sts;

	evad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (audio.valid),
		.in_kind  (audio.kind),
		.in_last  (audio.last),
		.in_ready (audio.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	evad_datapath #(
		.MAX_CHUNK (MAX_CHUNK)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_wdata      (cfg_wdata),
		.in_sample      (audio.sample),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.out_voiced     (result.voiced),
		.out_utt_done   (result.utt_done),
		.out_elapsed_ms (result.elapsed_ms)
	);

endmodule

FILE: verif/tb_energy_voice_activity_detector.sv
// Testbench for energy_voice_activity_detector: drives audio transactions and register
// writes, predicts the verdict of every chunk and checks the result channel against it.
// Depends on evad_pkg, evad_in_if, evad_out_if and the RTL top level.
module tb_energy_voice_activity_detector;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_CHUNK     = 4096;
	localparam int SETTLE_CYCLES = 40;   // margin for a chunk end to finish
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic                                 kind;
		logic signed [evad_pkg::SAMPLE_W-1:0] sample;
		logic                                 last;
	} audio_item_t;

	typedef struct packed {
		logic                      voiced;
		logic                      utt_done;
		logic [evad_pkg::MS_W-1:0] elapsed_ms;
	} verdict_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [evad_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [evad_pkg::CFG_W-1:0]     cfg_wdata;

	evad_in_if  audio();
	evad_out_if result();

	energy_voice_activity_detector #(.MAX_CHUNK(MAX_CHUNK)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.audio     (audio),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// detector state as the testbench sees it
	logic [evad_pkg::RATE_W-1:0] rate_q     = evad_pkg::RST_SAMPLE_RATE;
	logic [evad_pkg::THR_W-1:0]  thr_q      = evad_pkg::RST_ENERGY_THRESHOLD;
	logic [evad_pkg::MS_W-1:0]   sil_end_q  = evad_pkg::RST_SILENCE_END_MS;
	logic [evad_pkg::MS_W-1:0]   max_ms_q   = evad_pkg::RST_MAX_UTTERANCE_MS;
	logic [63:0]                 sq_sum     = '0;
	int unsigned                 sq_count   = 0;
	logic [evad_pkg::MS_W-1:0]   quiet_time = '0;
	logic [evad_pkg::MS_W-1:0]   run_time   = '0;
	logic                        heard_speech = 1'b0;

	audio_item_t pending_audio[$];
	verdict_t    due_verdicts[$];

	int   errors       = 0;
	logic calm         = 1'b0;
	int   holds_asked  = 0;
	int   holds_served = 0;
	int   stall_left   = 0;

	function automatic logic [evad_pkg::MS_W-1:0] ms_sat_add(logic [evad_pkg::MS_W-1:0] a,
		logic [evad_pkg::MS_W-1:0] b);
		logic [evad_pkg::MS_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[evad_pkg::MS_W] ? '1 : s[evad_pkg::MS_W-1:0];
	endfunction

	function automatic void score_audio(audio_item_t it);
		logic [16:0] mag;
		logic [63:0] mean_sq;
		logic [63:0] chunk_len;
		logic [63:0] rate;
		verdict_t    v;
		if (it.kind) begin
			quiet_time   = '0;
			run_time     = '0;
			heard_speech = 1'b0;
			return;
		end
		// samples beyond MAX_CHUNK are dropped, last still closes the chunk
		if (sq_count < MAX_CHUNK) begin
			mag = it.sample[evad_pkg::SAMPLE_W-1] ? 17'h10000 - {1'b0, it.sample}
				: {1'b0, it.sample};
			sq_sum = sq_sum + 64'(mag) * 64'(mag);
			sq_count++;
		end
		if (!it.last)
			return;
		rate      = (rate_q == '0) ? 64'd1 : 64'(rate_q);
		mean_sq   = (sq_count == 0) ? 64'd0 : sq_sum / 64'(sq_count);
		chunk_len = 64'(sq_count) * 64'(evad_pkg::MS_PER_S) / rate;
		if (chunk_len > 64'hFFFF_FFFF)
			chunk_len = 64'hFFFF_FFFF;
		run_time = ms_sat_add(run_time, chunk_len[evad_pkg::MS_W-1:0]);
		v.voiced = mean_sq > 64'(thr_q);
		if (v.voiced) begin
			heard_speech = 1'b1;
			quiet_time   = '0;
		end else begin
			quiet_time = ms_sat_add(quiet_time, chunk_len[evad_pkg::MS_W-1:0]);
		end
		v.utt_done   = (heard_speech && quiet_time >= sil_end_q) || run_time >= max_ms_q;
		v.elapsed_ms = run_time;
		sq_sum   = '0;
		sq_count = 0;
		due_verdicts.push_back(v);
	endfunction

	// audio driver
	always @(posedge clk) begin : drive_audio
		audio_item_t nxt;
		if (!arst_n) begin
			audio.valid <= 1'b0;
		end else if (!audio.valid || audio.ready) begin
			if (audio.valid)
				score_audio({audio.kind, audio.sample, audio.last});
			if (pending_audio.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
				nxt = pending_audio.pop_front();
				audio.valid  <= 1'b1;
				audio.kind   <= nxt.kind;
				audio.sample <= nxt.sample;
				audio.last   <= nxt.last;
			end else begin
				audio.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted in cycles
	always @(posedge clk) begin : hold_timer
		if (holds_served != holds_asked) begin
			holds_served <= holds_served + 1;
			stall_left   <= HOLD_CYCLES;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	// result monitor and checker
	always @(posedge clk) begin : watch_results
		verdict_t want;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (due_verdicts.size() == 0) begin
					$error("unexpected result transaction: elapsed_ms %0d", result.elapsed_ms);
					errors++;
				end else begin
					want = due_verdicts.pop_front();
					if (result.voiced !== want.voiced) begin
						$error("voiced: expected %0d, got %0d", want.voiced,
							result.voiced);
						errors++;
					end
					if (result.utt_done !== want.utt_done) begin
						$error("utt_done: expected %0d, got %0d",
							want.utt_done, result.utt_done);
						errors++;
					end
					if (result.elapsed_ms !== want.elapsed_ms) begin
						$error("elapsed_ms: expected %0d, got %0d", want.elapsed_ms,
							result.elapsed_ms);
						errors++;
					end
				end
			end
			if (stall_left != 0)
				result.ready <= 1'b0;
			else
				result.ready <= calm || $urandom_range(99) >= 6;
		end
	end

	function automatic void push_item(logic kind, logic [evad_pkg::SAMPLE_W-1:0] sample,
		logic last);
		audio_item_t it;
		it.kind   = kind;
		it.sample = sample;
		it.last   = last;
		pending_audio.push_back(it);
	endfunction

	function automatic void push_restart();
		push_item(1'b1, evad_pkg::SAMPLE_W'($urandom), 1'($urandom));
	endfunction

	// len samples uniform in [-amp, amp]; close puts last on the final one
	function automatic void push_samples(int len, int amp, bit close);
		for (int i = 0; i < len; i++)
			push_item(1'b0, evad_pkg::SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp),
				close && i == len - 1);
	endfunction

	task automatic write_reg(logic [evad_pkg::CFG_IDX_W-1:0] idx,
		logic [evad_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		case (idx)
			evad_pkg::REG_SAMPLE_RATE:      rate_q    = value[evad_pkg::RATE_W-1:0];
			evad_pkg::REG_ENERGY_THRESHOLD: thr_q     = value[evad_pkg::THR_W-1:0];
			evad_pkg::REG_SILENCE_END_MS:   sil_end_q = value[evad_pkg::MS_W-1:0];
			evad_pkg::REG_MAX_UTTERANCE_MS: max_ms_q  = value[evad_pkg::MS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [evad_pkg::CFG_W-1:0] rate, logic [evad_pkg::CFG_W-1:0] thr,
		logic [evad_pkg::CFG_W-1:0] sil_end, logic [evad_pkg::CFG_W-1:0] max_ms);
		write_reg(evad_pkg::REG_SAMPLE_RATE, rate);
		write_reg(evad_pkg::REG_ENERGY_THRESHOLD, thr);
		write_reg(evad_pkg::REG_SILENCE_END_MS, sil_end);
		write_reg(evad_pkg::REG_MAX_UTTERANCE_MS, max_ms);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// all transactions accepted, all verdicts seen, then let the chunk engine settle
	task automatic drain();
		while (!(pending_audio.size() == 0 && !audio.valid && due_verdicts.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int          made;
		int          len;
		int          amp;
		logic [31:0] r;
		logic [31:0] t;
		logic [31:0] s;
		logic [31:0] m;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = evad_pkg::REG_SAMPLE_RATE;
		cfg_wdata    = '0;
		audio.valid  = 1'b0;
		audio.kind   = 1'b0;
		audio.sample = '0;
		audio.last   = 1'b0;
		result.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: extreme samples, restart with a chunk half gathered
		push_item(1'b0, 16'h8000, 1'b1);
		push_item(1'b0, 16'h7FFF, 1'b0);
		push_item(1'b0, 16'h0000, 1'b0);
		push_item(1'b0, 16'hFFFF, 1'b1);
		push_item(1'b1, 16'h7FFF, 1'b1);
		push_item(1'b0, 16'd5, 1'b0);
		push_item(1'b0, 16'd6, 1'b0);
		push_item(1'b1, 16'h8000, 1'b0);
		push_item(1'b0, 16'd7, 1'b1);
		push_samples(8, 0, 1);
		drain();

		// zero rate counts as 1 Hz; zero limits end every chunk
		configure(32'd0, 32'd0, 32'd0, 32'd0);
		push_samples(2, 0, 1);
		push_item(1'b0, 16'h8000, 1'b1);
		drain();

		// mean square equal to the threshold is not speech
		configure(32'd192000, 32'h4000_0000, '1, '1);
		push_item(1'b0, 16'h8000, 1'b0);
		push_item(1'b0, 16'h8000, 1'b0);
		push_item(1'b0, 16'h8000, 1'b1);
		push_samples(3, 32767, 1);
		drain();

		for (int p = 0; p < 5; p++) begin
			case ($urandom_range(5))
				0: r = 32'd1000;
				1: r = 32'd16000;
				2: r = 32'd8000;
				3: r = 32'd100;
				4: r = 32'd192000;
				default: r = $urandom_range(1, 192000);
			endcase
			case ($urandom_range(3))
				0: t = 32'd100000;
				1: t = $urandom_range(0, 50000);
				2: t = $urandom_range(0, 32'h4000_0000);
				default: t = 32'd0;
			endcase
			s = ($urandom_range(4) == 0) ? '1 : $urandom_range(0, 300);
			m = ($urandom_range(4) == 0) ? '1 : $urandom_range(0, 400);
			configure(r, t, s, m);
			calm = (p == 2);
			made = 0;
			while (made < 80) begin
				case ($urandom_range(19))
					0: begin
						push_restart();
						made++;
					end
					1: begin
						// broken chunk cut by a restart
						len = $urandom_range(1, 4);
						push_samples(len, $urandom_range(0, 32767), 1'b0);
						push_restart();
						made += len + 1;
					end
					default: begin
						len = ($urandom_range(9) == 0) ? $urandom_range(17, 64)
							: $urandom_range(1, 16);
						amp = $urandom_range(1) ? $urandom_range(4000, 32767)
							: $urandom_range(0, 300);
						push_samples(len, amp, 1'b1);
						made += len;
					end
				endcase
			end
			drain();
			calm = 1'b0;
		end

		// receiver holds off while short chunks keep coming, so intake backs up
		configure(32'd1000, 32'd100000, 32'd20, 32'd200);
		holds_asked++;
		for (int c = 0; c < 20; c++)
			push_samples($urandom_range(1, 3), $urandom_range(0, 32767), 1'b1);
		drain();

		if (errors == 0)
			$display("[energy_voice_activity_detector] OK");
		else
			$display("[energy_voice_activity_detector] ERROR");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("[energy_voice_activity_detector] ERROR");
		$finish;
	end

endmodule
